/* hw/rtl/pip_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pip_pkg;

    localparam int COORD_W   = 32;
    localparam int SLOT_W    = 6;
    localparam int CNT_REG_W = 7;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * DIFF_W;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_TEST  = 1'b1;

    // word travelling down the cell chain (valid bit travels beside it)
    typedef struct packed {
        logic                 is_test;
        logic [SLOT_W-1:0]    slot;
        logic [COORD_W-1:0]   px;
        logic [COORD_W-1:0]   py;
        logic [COORD_W-1:0]   prev_x;
        logic [COORD_W-1:0]   prev_y;
        logic [COORD_W-1:0]   first_x;
        logic [COORD_W-1:0]   first_y;
        logic                 parity;
    } pip_tok_t;

endpackage

`default_nettype wire

/* hw/rtl/pip_edge.sv */
`timescale 1ns / 1ps
`default_nettype none

module pip_edge (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         adv,
    input  wire                         in_vld,
    input  wire pip_pkg::pip_tok_t      in_tok,
    input  wire [pip_pkg::COORD_W-1:0]  vi_x,
    input  wire [pip_pkg::COORD_W-1:0]  vi_y,
    input  wire [pip_pkg::COORD_W-1:0]  vj_x,
    input  wire [pip_pkg::COORD_W-1:0]  vj_y,
    input  wire                         edge_en,
    output logic                        out_vld,
    output pip_pkg::pip_tok_t           out_tok
);

    logic signed [pip_pkg::DIFF_W-1:0] px_e, py_e, xi_e, yi_e, xj_e, yj_e;
    logic signed [pip_pkg::DIFF_W-1:0] a_next, b_next, c_next, dy_next;
    logic                              straddle;

    logic                              s1_vld_reg;
    pip_pkg::pip_tok_t                 s1_tok_reg;
    logic signed [pip_pkg::DIFF_W-1:0] s1_a_reg, s1_b_reg, s1_c_reg, s1_dy_reg;
    logic                              s1_edge_reg;

    logic                              s2_vld_reg;
    pip_pkg::pip_tok_t                 s2_tok_reg;
    logic signed [pip_pkg::PROD_W-1:0] s2_l_reg, s2_r_reg;
    logic                              s2_edge_reg;
    logic                              s2_dyneg_reg;

    logic                              toggle;
    pip_pkg::pip_tok_t                 out_tok_next;
    logic                              out_vld_reg;
    pip_pkg::pip_tok_t                 out_tok_reg;

    // sign-extend to keep every difference exact
    always_comb begin
        px_e = $signed({in_tok.px[pip_pkg::COORD_W-1], in_tok.px});
        py_e = $signed({in_tok.py[pip_pkg::COORD_W-1], in_tok.py});
        xi_e = $signed({vi_x[pip_pkg::COORD_W-1], vi_x});
        yi_e = $signed({vi_y[pip_pkg::COORD_W-1], vi_y});
        xj_e = $signed({vj_x[pip_pkg::COORD_W-1], vj_x});
        yj_e = $signed({vj_y[pip_pkg::COORD_W-1], vj_y});
        a_next   = py_e - yi_e;
        b_next   = xj_e - xi_e;
        c_next   = px_e - xi_e;
        dy_next  = yj_e - yi_e;
        // exactly one end strictly below the point
        straddle = (yi_e < py_e) != (yj_e < py_e);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            s1_vld_reg  <= in_vld;
            s2_vld_reg  <= s1_vld_reg;
            out_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_tok_reg   <= in_tok;
            s1_a_reg     <= a_next;
            s1_b_reg     <= b_next;
            s1_c_reg     <= c_next;
            s1_dy_reg    <= dy_next;
            s1_edge_reg  <= edge_en && straddle;
            s2_tok_reg   <= s1_tok_reg;
            s2_l_reg     <= s1_a_reg * s1_b_reg;
            s2_r_reg     <= s1_c_reg * s1_dy_reg;
            s2_edge_reg  <= s1_edge_reg;
            s2_dyneg_reg <= s1_dy_reg[pip_pkg::DIFF_W-1];
            out_tok_reg  <= out_tok_next;
        end
    end

    // crossing left of the point, sign of dy flips the compare
    always_comb begin
        toggle = s2_edge_reg && (s2_dyneg_reg ? (s2_l_reg > s2_r_reg)
                                              : (s2_l_reg < s2_r_reg));
        out_tok_next        = s2_tok_reg;
        out_tok_next.parity = s2_tok_reg.parity ^ toggle;
    end

    assign out_vld = out_vld_reg;
    assign out_tok = out_tok_reg;

endmodule

`default_nettype wire

/* hw/rtl/pip_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module pip_cell #(
    parameter int CELL_IDX = 0,
    parameter int CNT_W    = 7
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     adv,
    input  wire [CNT_W-1:0]         n_eff,
    input  wire                     in_vld,
    input  wire pip_pkg::pip_tok_t  in_tok,
    output logic                    out_vld,
    output pip_pkg::pip_tok_t       out_tok
);

    localparam int SW = (CNT_W > pip_pkg::SLOT_W) ? CNT_W : pip_pkg::SLOT_W;

    logic [pip_pkg::COORD_W-1:0] vx_reg;
    logic [pip_pkg::COORD_W-1:0] vy_reg;
    logic                        wr_hit;
    logic                        active;
    logic                        edge_en;
    pip_pkg::pip_tok_t           tok_mod;

    always_comb begin
        wr_hit  = in_vld && !in_tok.is_test
                  && (SW'(in_tok.slot) == SW'(CELL_IDX));
        active  = in_vld && in_tok.is_test && (CNT_W'(CELL_IDX) < n_eff);
        // the first cell only records its vertex, the closing edge is done at the tail
        edge_en = active && (CELL_IDX != 0);
        tok_mod = in_tok;
        if (active) begin
            tok_mod.prev_x = vx_reg;
            tok_mod.prev_y = vy_reg;
            if (CELL_IDX == 0) begin
                tok_mod.first_x = vx_reg;
                tok_mod.first_y = vy_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && wr_hit) begin
            vx_reg <= in_tok.px;
            vy_reg <= in_tok.py;
        end
    end

    pip_edge u_edge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .in_vld  (in_vld),
        .in_tok  (tok_mod),
        .vi_x    (vx_reg),
        .vi_y    (vy_reg),
        .vj_x    (in_tok.prev_x),
        .vj_y    (in_tok.prev_y),
        .edge_en (edge_en),
        .out_vld (out_vld),
        .out_tok (out_tok)
    );

endmodule

`default_nettype wire

/* hw/rtl/point_in_polygon_test_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake            payload
// s_        in   s_tvalid / s_tready  tdata: vertex_index, coord_x, coord_y; tuser: command
// m_        out  m_tvalid / m_tready  tdata: inside_res
// cfg_      in   cfg_wr_en            cfg_wr_data: vertex_count
//
// one word accepted per cycle while the chain is not stalled
// the chain holds one three-stage cell per vertex slot plus a closing cell,
// each cell holding two 33x33 multipliers and a wide compare
// reset clears vertex_count and every valid bit; stored vertices stay undefined until written
// the chain stalls only when a test result reaches the tail while the output word is held

module point_in_polygon_test_top #(
    parameter int MAX_VERTICES = 64
) (
    input  wire         aclk,
    input  wire         aresetn,
    // configuration
    input  wire         cfg_wr_en,
    input  wire [6:0]   cfg_wr_data,  // vertex_count
    // input words
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire [71:0]  s_tdata,      // vertex_index[5:0], coord_x[37:6], coord_y[69:38], zero pad
    input  wire [0:0]   s_tuser,      // command
    // result words
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [7:0]  m_tdata       // inside_res[0], zero pad
);

    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int CMP_W = (CNT_W > pip_pkg::CNT_REG_W) ? CNT_W : pip_pkg::CNT_REG_W;

    // vertex count register and clamp to the number of cells
    logic [pip_pkg::CNT_REG_W-1:0] count_reg;
    logic [CMP_W-1:0]              count_ext;
    logic [CNT_W-1:0]              n_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cfg_wr_en) begin
            count_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        count_ext = CMP_W'(count_reg);
        if (count_ext > CMP_W'(MAX_VERTICES)) begin
            n_eff = CNT_W'(MAX_VERTICES);
        end else begin
            n_eff = CNT_W'(count_ext);
        end
    end

    // chain links: entry word, one link per cell, tail into the closing cell
    wire [MAX_VERTICES:0]     chain_vld;
    wire pip_pkg::pip_tok_t   chain_tok [MAX_VERTICES+1];
    pip_pkg::pip_tok_t        entry_tok;

    logic                     adv;
    logic                     tail_vld;
    pip_pkg::pip_tok_t        tail_tok;
    logic                     close_en;

    logic                     m_valid_reg;
    logic                     m_inside_reg;

    // unpack the input word, trailing vertices start cleared
    always_comb begin
        entry_tok         = '0;
        entry_tok.is_test = (s_tuser[0] == pip_pkg::CMD_TEST);
        entry_tok.slot    = s_tdata[5:0];
        entry_tok.px      = s_tdata[37:6];
        entry_tok.py      = s_tdata[69:38];
    end

    assign chain_vld[0] = s_tvalid && aresetn;
    assign chain_tok[0] = entry_tok;

    genvar k;
    generate
        for (k = 0; k < MAX_VERTICES; k++) begin : g_cell
            pip_cell #(
                .CELL_IDX (k),
                .CNT_W    (CNT_W)
            ) u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .adv     (adv),
                .n_eff   (n_eff),
                .in_vld  (chain_vld[k]),
                .in_tok  (chain_tok[k]),
                .out_vld (chain_vld[k+1]),
                .out_tok (chain_tok[k+1])
            );
        end
    endgenerate

    // closing edge: last used vertex back to vertex zero
    assign close_en = chain_vld[MAX_VERTICES] && chain_tok[MAX_VERTICES].is_test
                      && (n_eff != '0);

    pip_edge u_close (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .in_vld  (chain_vld[MAX_VERTICES]),
        .in_tok  (chain_tok[MAX_VERTICES]),
        .vi_x    (chain_tok[MAX_VERTICES].first_x),
        .vi_y    (chain_tok[MAX_VERTICES].first_y),
        .vj_x    (chain_tok[MAX_VERTICES].prev_x),
        .vj_y    (chain_tok[MAX_VERTICES].prev_y),
        .edge_en (close_en),
        .out_vld (tail_vld),
        .out_tok (tail_tok)
    );

    // hold the chain only if a test result would overwrite a waiting word
    assign adv      = !(tail_vld && tail_tok.is_test && m_valid_reg && !m_tready);
    assign s_tready = adv && aresetn;

    // output register, write words are dropped at the tail
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv && tail_vld && tail_tok.is_test) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && tail_vld && tail_tok.is_test) begin
            m_inside_reg <= tail_tok.parity;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, m_inside_reg};

    // a test reaching the tail always shows up as a result word
    a_tail_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && tail_vld && tail_tok.is_test) |=> (m_tvalid && (m_tdata[0] == $past(tail_tok.parity))))
        else $error("tail test word not moved to output");

    // with no vertices no crossing may be counted
    a_empty_outside: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && tail_vld && tail_tok.is_test && (n_eff == '0)) |=> !m_tdata[0])
        else $error("empty polygon reported inside");

    // a single vertex has no straddling edge
    a_single_outside: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && tail_vld && tail_tok.is_test && (n_eff == CNT_W'(1))) |=> !m_tdata[0])
        else $error("single vertex polygon reported inside");

    // input is held back only by a blocked output word
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready && tail_vld))
        else $error("input stalled without output backpressure");

endmodule

`default_nettype wire
